// ===== rtl/core/crlb_pkg.sv =====
// Package for the credit limited reorder buffer.
// Holds the request and result types, action and result codes.
// No dependencies.
package crlb_pkg;

  localparam logic [1:0] ACT_RESERVE = 2'd0;
  localparam logic [1:0] ACT_PUBLISH = 2'd1;
  localparam logic [1:0] ACT_RELEASE = 2'd2;
  localparam logic [1:0] ACT_STATUS  = 2'd3;

  localparam logic [2:0] KIND_GRANTED  = 3'd0;
  localparam logic [2:0] KIND_FULL     = 3'd1;
  localparam logic [2:0] KIND_EMITTED  = 3'd2;
  localparam logic [2:0] KIND_HELD     = 3'd3;
  localparam logic [2:0] KIND_REJECTED = 3'd4;
  localparam logic [2:0] KIND_STATUS   = 3'd5;

  localparam logic [4:0] CREDIT_RESET = 5'd16;

  typedef struct packed {
    logic [1:0]  action;
    logic [31:0] seq;
    logic [31:0] payload;
  } req_t;

  typedef struct packed {
    logic [2:0]  kind;
    logic [31:0] out_seq;
    logic [31:0] out_payload;
    logic [4:0]  in_flight;
    logic        idle;
    logic        last;
  } rsp_t;

endpackage

// ===== rtl/core/crlb_ram.sv =====
// Generic simple dual-port RAM, one write port and one registered read port.
// No dependencies.
module crlb_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     wr_en,
  input  logic [$clog2(DEPTH)-1:0] wr_addr,
  input  logic [WIDTH-1:0]         wr_data,
  input  logic                     rd_en,
  input  logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

// ===== rtl/core/crlb_rsp_queue.sv =====
// Two-entry result queue between the buffer logic and the result channel.
// Depends on crlb_pkg for the result type.
module crlb_rsp_queue (
  input  logic          clk,
  input  logic          rst,
  input  logic          push,
  input  crlb_pkg::rsp_t push_data,
  output logic          can_push,
  output logic          rsp_valid,
  input  logic          rsp_stall,
  output crlb_pkg::rsp_t rsp
);

  crlb_pkg::rsp_t q0;
  crlb_pkg::rsp_t q1;
  logic [1:0]     count;
  logic           pop;

  assign pop       = (count != 2'd0) && !rsp_stall;
  assign can_push  = (count != 2'd2);
  assign rsp_valid = (count != 2'd0);
  assign rsp       = q0;

  always_ff @(posedge clk) begin
    if (rst) begin
      count <= 2'd0;
    end else begin
      case ({push, pop})
        2'b10: count <= count + 2'd1;
        2'b01: count <= count - 2'd1;
        default: count <= count;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    case ({push, pop})
      2'b10: begin
        if (count == 2'd0) begin
          q0 <= push_data;
        end else begin
          q1 <= push_data;
        end
      end
      2'b01: begin
        q0 <= q1;
      end
      2'b11: begin
        if (count == 2'd1) begin
          q0 <= push_data;
        end else begin
          q0 <= q1;
          q1 <= push_data;
        end
      end
      default: begin
        q0 <= q0;
      end
    endcase
  end

endmodule

// ===== rtl/core/credit_limited_reorder_buffer.sv =====
// Credit limited reorder buffer with in-order release.
// Requests arrive on req_valid/req_stall with a req_t payload; results leave on
// rsp_valid/rsp_stall with a rsp_t payload. cfg_we/cfg_wdata write credit_limit.
// Reserve, release, status, a rejected publish and a held publish each give one
// result, registered into the result queue when the request is taken; the next
// request may follow in the next cycle unless the queue is full. A publish of the
// next-in-order sequence number gives a burst of k emitted results: the first
// carries the request's own payload, the rest are read from the payload RAM, one
// per cycle while the queue has space; the block takes no request during a burst.
// Results pass through a two-entry queue: one result may wait while the next
// request is taken. When the receiver stalls and the queue is full, req_stall
// rises and a burst pauses until space returns.
// Reset (synchronous, rst high) clears every slot's valid bit, the grant and
// emit counters, the in-flight count and the ring head, and sets the credit
// limit to 16. The payload RAM needs no clearing.
// Depends on crlb_pkg, crlb_ram and crlb_rsp_queue.
module credit_limited_reorder_buffer #(
  parameter int DEPTH         = 16,
  parameter int PAYLOAD_WIDTH = 32
) (
  input  logic           clk,
  input  logic           rst,
  input  logic           req_valid,
  output logic           req_stall,
  input  crlb_pkg::req_t req,
  output logic           rsp_valid,
  input  logic           rsp_stall,
  output crlb_pkg::rsp_t rsp,
  input  logic           cfg_we,
  input  logic [4:0]     cfg_wdata
);

  localparam int IDXW    = $clog2(DEPTH);
  localparam int STORE_W = (PAYLOAD_WIDTH < 32) ? PAYLOAD_WIDTH : 32;
  localparam int LIMW    = 10;

  localparam logic ST_IDLE = 1'b0;
  localparam logic ST_EMIT = 1'b1;

  logic                state;
  logic                state_next;
  logic [IDXW-1:0]     head;
  logic [IDXW-1:0]     head_next;
  logic [IDXW-1:0]     head_inc;
  logic [31:0]         grant_seq;
  logic [31:0]         grant_seq_next;
  logic [31:0]         emit_seq;
  logic [31:0]         emit_seq_next;
  logic [4:0]          outstanding;
  logic [4:0]          outstanding_next;
  logic [4:0]          outstanding_dec;
  logic [4:0]          credit_limit;
  logic [DEPTH-1:0]    slot_valid;
  logic [DEPTH-1:0]    slot_valid_next;

  logic                accept;
  logic                can_push;
  logic                push;
  crlb_pkg::rsp_t      push_data;

  logic [31:0]         off;
  logic                in_window;
  logic [IDXW:0]       idx_sum;
  logic [IDXW-1:0]     idx;
  logic                credit_ok;

  logic                wr_en;
  logic                rd_en;
  logic [IDXW-1:0]     rd_addr;
  logic [STORE_W-1:0]  rd_data;

  assign req_stall = (state != ST_IDLE) || !can_push;
  assign accept    = req_valid && !req_stall;

  assign head_inc        = (head == IDXW'(DEPTH - 1)) ? '0 : head + IDXW'(1);
  assign outstanding_dec = (outstanding != 5'd0) ? outstanding - 5'd1 : 5'd0;

  assign off       = req.seq - emit_seq;
  assign in_window = off < 32'(DEPTH);
  assign idx_sum   = {1'b0, head} + {1'b0, off[IDXW-1:0]};
  assign idx       = (idx_sum >= (IDXW+1)'(DEPTH)) ? IDXW'(idx_sum - (IDXW+1)'(DEPTH))
                                                   : idx_sum[IDXW-1:0];

  assign credit_ok = (LIMW'(outstanding) < LIMW'(credit_limit))
                  && (LIMW'(outstanding) < LIMW'(DEPTH));

  assign wr_en = accept && (req.action == crlb_pkg::ACT_PUBLISH) && in_window
              && !slot_valid[idx] && (off != 32'd0);

  always_comb begin
    state_next       = state;
    head_next        = head;
    grant_seq_next   = grant_seq;
    emit_seq_next    = emit_seq;
    outstanding_next = outstanding;
    slot_valid_next  = slot_valid;
    push             = 1'b0;
    push_data        = '0;
    rd_en            = 1'b0;
    rd_addr          = head_inc;

    if (state == ST_IDLE) begin
      if (accept) begin
        push           = 1'b1;
        push_data.last = 1'b1;
        case (req.action)
          crlb_pkg::ACT_RESERVE: begin
            if (credit_ok) begin
              grant_seq_next         = grant_seq + 32'd1;
              outstanding_next       = outstanding + 5'd1;
              push_data.kind         = crlb_pkg::KIND_GRANTED;
              push_data.out_seq      = grant_seq;
            end else begin
              push_data.kind         = crlb_pkg::KIND_FULL;
            end
          end
          crlb_pkg::ACT_PUBLISH: begin
            if (!in_window || slot_valid[idx]) begin
              push_data.kind    = crlb_pkg::KIND_REJECTED;
              push_data.out_seq = req.seq;
            end else if (off != 32'd0) begin
              slot_valid_next[idx] = 1'b1;
              push_data.kind       = crlb_pkg::KIND_HELD;
              push_data.out_seq    = req.seq;
            end else begin
              outstanding_next      = outstanding_dec;
              head_next             = head_inc;
              emit_seq_next         = emit_seq + 32'd1;
              push_data.kind        = crlb_pkg::KIND_EMITTED;
              push_data.out_seq     = req.seq;
              push_data.out_payload = 32'(req.payload[STORE_W-1:0]);
              push_data.last        = !slot_valid[head_inc];
              if (slot_valid[head_inc]) begin
                rd_en      = 1'b1;
                state_next = ST_EMIT;
              end
            end
          end
          crlb_pkg::ACT_RELEASE: begin
            outstanding_next = outstanding_dec;
            push_data.kind   = crlb_pkg::KIND_STATUS;
          end
          default: begin
            push_data.kind = crlb_pkg::KIND_STATUS;
          end
        endcase
        push_data.in_flight = outstanding_next;
        push_data.idle      = (outstanding_next == 5'd0);
      end
    end else begin
      if (can_push) begin
        push                  = 1'b1;
        slot_valid_next[head] = 1'b0;
        head_next             = head_inc;
        emit_seq_next         = emit_seq + 32'd1;
        outstanding_next      = outstanding_dec;
        push_data.kind        = crlb_pkg::KIND_EMITTED;
        push_data.out_seq     = emit_seq;
        push_data.out_payload = 32'(rd_data);
        push_data.in_flight   = outstanding_dec;
        push_data.idle        = (outstanding_dec == 5'd0);
        push_data.last        = !slot_valid[head_inc];
        if (slot_valid[head_inc]) begin
          rd_en = 1'b1;
        end else begin
          state_next = ST_IDLE;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= ST_IDLE;
      head         <= '0;
      grant_seq    <= 32'd0;
      emit_seq     <= 32'd0;
      outstanding  <= 5'd0;
      slot_valid   <= '0;
      credit_limit <= crlb_pkg::CREDIT_RESET;
    end else begin
      state       <= state_next;
      head        <= head_next;
      grant_seq   <= grant_seq_next;
      emit_seq    <= emit_seq_next;
      outstanding <= outstanding_next;
      slot_valid  <= slot_valid_next;
      if (cfg_we) begin
        credit_limit <= cfg_wdata;
      end
    end
  end

  crlb_ram #(
    .WIDTH (STORE_W),
    .DEPTH (DEPTH)
  ) u_payload_ram (
    .clk     (clk),
    .wr_en   (wr_en),
    .wr_addr (idx),
    .wr_data (req.payload[STORE_W-1:0]),
    .rd_en   (rd_en),
    .rd_addr (rd_addr),
    .rd_data (rd_data)
  );

  crlb_rsp_queue u_rsp_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .push_data (push_data),
    .can_push  (can_push),
    .rsp_valid (rsp_valid),
    .rsp_stall (rsp_stall),
    .rsp       (rsp)
  );

endmodule
